/* sv/tfpc_pkg.sv */
// ----------------------------------------------------------------------------
// tfpc_pkg
// Shared types and constants for the four-point touch calibration unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tfpc_pkg;

	// field widths
	localparam int RAW_WIDTH  = 12;
	localparam int CFG_WIDTH  = 11;
	localparam int OUT_WIDTH  = 16;
	localparam int NUM_CORNERS = 4;
	localparam int SLOT_W     = $clog2(NUM_CORNERS);

	// datapath widths
	localparam int OFS_W  = CFG_WIDTH + 1;          // signed offset and span
	localparam int DIFF_W = RAW_WIDTH + 1;          // signed far - near
	localparam int PROD_W = OFS_W + DIFF_W;         // signed product
	localparam int MAG_W  = PROD_W - 1;             // product magnitude
	localparam int DIV_W  = CFG_WIDTH;              // divisor magnitude
	localparam int CNT_W  = $clog2(MAG_W + 1);
	localparam int VAL_W  = PROD_W + 1;             // extrapolated value

	// target insets
	localparam logic [OFS_W-1:0] INSET_X = OFS_W'(80);
	localparam logic [OFS_W-1:0] INSET_Y = OFS_W'(60);

	// register indexes
	localparam logic REG_SCREEN_WIDTH  = 1'b0;
	localparam logic REG_SCREEN_HEIGHT = 1'b1;

	// reset values of the screen size
	localparam logic [CFG_WIDTH-1:0] WIDTH_RESET  = CFG_WIDTH'(320);
	localparam logic [CFG_WIDTH-1:0] HEIGHT_RESET = CFG_WIDTH'(240);

	// extrapolation terms, in the order they are computed
	localparam logic [1:0] TERM_X0 = 2'd0;
	localparam logic [1:0] TERM_XW = 2'd1;
	localparam logic [1:0] TERM_Y0 = 2'd2;
	localparam logic [1:0] TERM_YH = 2'd3;

	typedef struct packed {
		logic [RAW_WIDTH-1:0] raw_x;
		logic [RAW_WIDTH-1:0] raw_y;
		logic                 sample_ok;
	} sample_t;

	typedef struct packed {
		logic signed [OUT_WIDTH-1:0] x_min;
		logic signed [OUT_WIDTH-1:0] x_max;
		logic signed [OUT_WIDTH-1:0] y_min;
		logic signed [OUT_WIDTH-1:0] y_max;
		logic                        swap_xy;
		logic                        invert_x;
		logic                        invert_y;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_AVG,
		ST_MUL,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic              store;
		logic [SLOT_W-1:0] slot;
		logic              avg;
		logic              mul;
		logic              div_go;
		logic              acc;
		logic              emit;
		logic [1:0]        term;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_done;
	} status_t;

endpackage

`default_nettype wire

/* sv/touch_four_point_calibration_unit.sv */
// ----------------------------------------------------------------------------
// touch_four_point_calibration_unit
// Four-point touch calibration: collects four corner samples and derives
// axis swap, raw range and inversion of each screen axis.
// ----------------------------------------------------------------------------
// A non-final or invalid sample leaves the unit idle; busy stays low.
// The fourth valid sample holds busy high through the edge averages and the
// four extrapolations through one shared 24-step restoring divider.
// done pulses one cycle, rising as busy falls; the receiver cannot stall it.
// Reset clears the corner count, controller and strobe, and sets the screen
// size to 320 x 240; corner storage is not cleared.
`default_nettype none

module touch_four_point_calibration_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire tfpc_pkg::sample_t           sample,
	output logic                             done,
	output tfpc_pkg::result_t                result,
	input  wire logic                        cfg_we,
	input  wire logic                        cfg_index,
	input  wire logic [tfpc_pkg::CFG_WIDTH-1:0] cfg_wdata
);
	import tfpc_pkg::*;

	cmd_t    cmd;
	status_t status;

	// sequencing
	tfpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.sample_ok (sample.sample_ok),
		.status    (status),
		.cmd       (cmd),
		.busy      (busy)
	);

	// arithmetic and storage
	tfpc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.sample    (sample),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.result    (result)
	);

endmodule

`default_nettype wire

/* sv/tfpc_div.sv */
// ----------------------------------------------------------------------------
// tfpc_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tfpc_div (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    go,
	input  wire logic [tfpc_pkg::MAG_W-1:0] dividend,
	input  wire logic [tfpc_pkg::DIV_W-1:0] divisor,
	output logic                         done,
	output logic [tfpc_pkg::MAG_W-1:0]   quotient
);
	import tfpc_pkg::*;

	logic              run_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [MAG_W-1:0]  quo_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  dvs_q;
	logic [DIV_W:0]    shifted;
	logic [DIV_W+1:0]  trial;

	// one restoring step
	always_comb begin
		shifted = {rem_q, quo_q[MAG_W-1]};
		trial   = {1'b0, shifted} - {2'b00, dvs_q};
	end

	// control of the iteration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == CNT_W'(1));
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(MAG_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1))
					run_q <= 1'b0;
			end
		end
	end

	// partial remainder and quotient
	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			if (!trial[DIV_W+1]) begin
				rem_q <= trial[DIV_W-1:0];
				quo_q <= {quo_q[MAG_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DIV_W-1:0];
				quo_q <= {quo_q[MAG_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

/* sv/tfpc_dp.sv */
// ----------------------------------------------------------------------------
// tfpc_dp
// Datapath: corner store, edge averages, extrapolation and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tfpc_dp (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire tfpc_pkg::cmd_t              cmd,
	output tfpc_pkg::status_t                status,
	input  wire tfpc_pkg::sample_t           sample,
	input  wire logic                        cfg_we,
	input  wire logic                        cfg_index,
	input  wire logic [tfpc_pkg::CFG_WIDTH-1:0] cfg_wdata,
	output logic                             done,
	output tfpc_pkg::result_t                result
);
	import tfpc_pkg::*;

	logic [CFG_WIDTH-1:0] screen_width_q;
	logic [CFG_WIDTH-1:0] screen_height_q;

	logic [RAW_WIDTH-1:0] corner_x_q [NUM_CORNERS];
	logic [RAW_WIDTH-1:0] corner_y_q [NUM_CORNERS];

	logic                 swap_q;
	logic [RAW_WIDTH-1:0] left_q, right_q, top_q, bottom_q;

	logic signed [PROD_W-1:0] prod_q;
	logic signed [OFS_W-1:0]  span_q;
	logic [RAW_WIDTH-1:0]     near_q;

	logic signed [VAL_W-1:0]  val_q [NUM_CORNERS];

	logic    done_q;
	result_t result_q;

	// swap decision and edge averages
	logic signed [DIFF_W-1:0] dx_down, dx_across;
	logic [RAW_WIDTH-1:0]     adx_down, adx_across;
	logic                     swap;
	logic [RAW_WIDTH:0]       sum_l, sum_r, sum_t, sum_b;

	always_comb begin
		dx_down    = $signed({1'b0, corner_x_q[0]}) - $signed({1'b0, corner_x_q[2]});
		dx_across  = $signed({1'b0, corner_x_q[0]}) - $signed({1'b0, corner_x_q[1]});
		adx_down   = dx_down[DIFF_W-1] ? RAW_WIDTH'(-dx_down) : dx_down[RAW_WIDTH-1:0];
		adx_across = dx_across[DIFF_W-1] ? RAW_WIDTH'(-dx_across) : dx_across[RAW_WIDTH-1:0];
		swap       = adx_down > adx_across;
		if (swap) begin
			sum_l = {1'b0, corner_y_q[0]} + {1'b0, corner_y_q[2]};
			sum_r = {1'b0, corner_y_q[1]} + {1'b0, corner_y_q[3]};
			sum_t = {1'b0, corner_x_q[0]} + {1'b0, corner_x_q[1]};
			sum_b = {1'b0, corner_x_q[2]} + {1'b0, corner_x_q[3]};
		end else begin
			sum_l = {1'b0, corner_x_q[0]} + {1'b0, corner_x_q[2]};
			sum_r = {1'b0, corner_x_q[1]} + {1'b0, corner_x_q[3]};
			sum_t = {1'b0, corner_y_q[0]} + {1'b0, corner_y_q[1]};
			sum_b = {1'b0, corner_y_q[2]} + {1'b0, corner_y_q[3]};
		end
	end

	// operand selection for the current term
	logic [RAW_WIDTH-1:0]    near, far;
	logic signed [OFS_W-1:0] offset, span;
	logic signed [DIFF_W-1:0] diff;

	always_comb begin
		near   = left_q;
		far    = right_q;
		offset = -$signed(INSET_X);
		span   = $signed({1'b0, screen_width_q}) - $signed(INSET_X << 1);
		case (cmd.term)
			TERM_X0: begin
				offset = -$signed(INSET_X);
			end
			TERM_XW: begin
				offset = $signed({1'b0, screen_width_q}) - $signed(INSET_X);
			end
			TERM_Y0: begin
				near   = top_q;
				far    = bottom_q;
				offset = -$signed(INSET_Y);
				span   = $signed({1'b0, screen_height_q}) - $signed(INSET_Y << 1);
			end
			default: begin
				near   = top_q;
				far    = bottom_q;
				offset = $signed({1'b0, screen_height_q}) - $signed(INSET_Y);
				span   = $signed({1'b0, screen_height_q}) - $signed(INSET_Y << 1);
			end
		endcase
		diff = $signed({1'b0, far}) - $signed({1'b0, near});
	end

	// divider operands as magnitudes
	logic [MAG_W-1:0] prod_mag;
	logic [DIV_W-1:0] span_mag;
	logic [MAG_W-1:0] quo_mag;
	logic             div_done;
	logic             q_neg;
	logic signed [VAL_W-1:0] q_signed;
	logic signed [VAL_W-1:0] term_val;

	always_comb begin
		prod_mag = prod_q[PROD_W-1] ? MAG_W'(-prod_q) : prod_q[MAG_W-1:0];
		span_mag = span_q[OFS_W-1] ? DIV_W'(-span_q) : span_q[DIV_W-1:0];
		q_neg    = prod_q[PROD_W-1] ^ span_q[OFS_W-1];
		q_signed = q_neg ? -$signed({2'b00, quo_mag}) : $signed({2'b00, quo_mag});
		// a zero span leaves the edge average as it is
		if (span_q == '0)
			term_val = $signed({{(VAL_W-RAW_WIDTH){1'b0}}, near_q});
		else
			term_val = $signed({{(VAL_W-RAW_WIDTH){1'b0}}, near_q}) + q_signed;
	end

	tfpc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (cmd.div_go),
		.dividend (prod_mag),
		.divisor  (span_mag),
		.done     (div_done),
		.quotient (quo_mag)
	);

	assign status.div_done = div_done;

	// min, max, flags and saturation
	function automatic logic signed [OUT_WIDTH-1:0] sat16(input logic signed [VAL_W-1:0] v);
		logic signed [VAL_W-1:0] hi;
		logic signed [VAL_W-1:0] lo;
		hi = VAL_W'(32767);
		lo = -VAL_W'(32768);
		if (v > hi)
			sat16 = 16'sh7fff;
		else if (v < lo)
			sat16 = 16'sh8000;
		else
			sat16 = v[OUT_WIDTH-1:0];
	endfunction

	result_t res;

	always_comb begin
		res.swap_xy  = swap_q;
		res.invert_x = val_q[TERM_X0] > val_q[TERM_XW];
		res.invert_y = val_q[TERM_Y0] > val_q[TERM_YH];
		res.x_min    = res.invert_x ? sat16(val_q[TERM_XW]) : sat16(val_q[TERM_X0]);
		res.x_max    = res.invert_x ? sat16(val_q[TERM_X0]) : sat16(val_q[TERM_XW]);
		res.y_min    = res.invert_y ? sat16(val_q[TERM_YH]) : sat16(val_q[TERM_Y0]);
		res.y_max    = res.invert_y ? sat16(val_q[TERM_Y0]) : sat16(val_q[TERM_YH]);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= WIDTH_RESET;
			screen_height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SCREEN_WIDTH:  screen_width_q  <= cfg_wdata;
				REG_SCREEN_HEIGHT: screen_height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= cmd.emit;
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.store) begin
			corner_x_q[cmd.slot] <= sample.raw_x;
			corner_y_q[cmd.slot] <= sample.raw_y;
		end
		if (cmd.avg) begin
			swap_q   <= swap;
			left_q   <= sum_l[RAW_WIDTH:1];
			right_q  <= sum_r[RAW_WIDTH:1];
			top_q    <= sum_t[RAW_WIDTH:1];
			bottom_q <= sum_b[RAW_WIDTH:1];
		end
		if (cmd.mul) begin
			prod_q <= offset * diff;
			span_q <= span;
			near_q <= near;
		end
		if (cmd.acc)
			val_q[cmd.term] <= term_val;
		if (cmd.emit)
			result_q <= res;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

/* sv/tfpc_ctrl.sv */
// ----------------------------------------------------------------------------
// tfpc_ctrl
// Controller: corner counting and sequencing of the four extrapolations.
// ----------------------------------------------------------------------------
`default_nettype none

module tfpc_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic              sample_ok,
	input  wire tfpc_pkg::status_t status,
	output tfpc_pkg::cmd_t         cmd,
	output logic                   busy
);
	import tfpc_pkg::*;

	state_t            state_q, state_d;
	logic [SLOT_W-1:0] count_q;
	logic [1:0]        term_q;
	logic              take;
	logic              last;

	assign take = start && (state_q == ST_IDLE);
	assign last = count_q == SLOT_W'(NUM_CORNERS - 1);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take && sample_ok && last)
					state_d = ST_AVG;
			end
			ST_AVG:    state_d = ST_MUL;
			ST_MUL:    state_d = ST_DIV_GO;
			ST_DIV_GO: state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (status.div_done)
					state_d = (term_q == TERM_YH) ? ST_OUT : ST_MUL;
			end
			ST_OUT:    state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd        = '0;
		cmd.slot   = count_q;
		cmd.term   = term_q;
		busy       = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy      = 1'b0;
				cmd.store = take && sample_ok;
			end
			ST_AVG:      cmd.avg    = 1'b1;
			ST_MUL:      cmd.mul    = 1'b1;
			ST_DIV_GO:   cmd.div_go = 1'b1;
			ST_DIV_WAIT: cmd.acc    = status.div_done;
			ST_OUT:      cmd.emit   = 1'b1;
			default:     busy       = 1'b1;
		endcase
	end

	// state, corner count and term index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			term_q  <= TERM_X0;
		end else begin
			state_q <= state_d;
			if (take) begin
				if (!sample_ok || last)
					count_q <= '0;
				else
					count_q <= count_q + SLOT_W'(1);
			end
			if (state_q == ST_AVG)
				term_q <= TERM_X0;
			else if (state_q == ST_DIV_WAIT && status.div_done)
				term_q <= term_q + 2'd1;
		end
	end

endmodule

`default_nettype wire
